@@ rtl/esd_pkg.sv @@
// Shared types, codes and constants for the escape sequence decoder.
`timescale 1ns / 1ps
package esd_pkg;

   localparam logic [1:0] REQ_BYTE     = 2'd0;
   localparam logic [1:0] REQ_BOUNDARY = 2'd1;
   localparam logic [1:0] REQ_END      = 2'd2;

   localparam logic [1:0] MODE_NORMAL = 2'd0;
   localparam logic [1:0] MODE_ESCAPE = 2'd1;
   localparam logic [1:0] MODE_OCTAL  = 2'd2;

   localparam logic [1:0] OCT_LAST_DIGIT = 2'd2;

   localparam logic [7:0] CH_BACKSLASH = 8'h5C;
   localparam logic [7:0] CH_ZERO      = 8'h30;
   localparam logic [7:0] CH_SPACE     = 8'h20;
   localparam logic [7:0] CH_NEWLINE   = 8'h0A;
   localparam logic [7:0] CH_LOWER_B   = 8'h62;
   localparam logic [7:0] CH_LOWER_C   = 8'h63;
   localparam logic [7:0] CH_LOWER_F   = 8'h66;
   localparam logic [7:0] CH_LOWER_N   = 8'h6E;
   localparam logic [7:0] CH_LOWER_R   = 8'h72;
   localparam logic [7:0] CH_LOWER_T   = 8'h74;
   localparam logic [7:0] CH_LOWER_V   = 8'h76;
   localparam logic [7:0] CH_BS        = 8'h08;
   localparam logic [7:0] CH_FF        = 8'h0C;
   localparam logic [7:0] CH_CR        = 8'h0D;
   localparam logic [7:0] CH_TAB       = 8'h09;
   localparam logic [7:0] CH_VT        = 8'o013;

   localparam logic [4:0] OCT_DIGIT_HIGH = 5'b00110;

   localparam int QUEUE_DEPTH = 4;
   localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

   typedef struct packed {
      logic       two;
      logic [7:0] byte0;
      logic [7:0] byte1;
      logic       list_end;
   } entry_type;

endpackage

@@ rtl/esd_front.sv @@
// Front end: accepts transactions, runs the escape decoder and builds queue entries.
`timescale 1ns / 1ps
module esd_front import esd_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  logic       csr_wr_en,
   input  logic       csr_wr_data,
   input  logic       req_valid,
   output logic       req_ready,
   input  logic [1:0] req_type,
   input  logic [7:0] req_in_byte,
   input  logic       queue_full,
   output logic       push,
   output entry_type  push_data
);

   logic [1:0] mode_ff, mode_in;
   logic [1:0] digits_ff, digits_in;
   logic [7:0] accum_ff, accum_in;
   logic       cancelled_ff, cancelled_in;
   logic       no_newline_ff;

   logic       accept;
   logic       has_a, has_b;
   logic [7:0] byte_b;
   logic [7:0] oct_next;

   assign req_ready = !queue_full;
   assign accept    = req_valid && req_ready;
   assign oct_next  = {accum_ff[4:0], req_in_byte[2:0]};

   always_comb begin
      mode_in      = mode_ff;
      digits_in    = digits_ff;
      accum_in     = accum_ff;
      cancelled_in = cancelled_ff;
      has_a        = 1'b0;
      has_b        = 1'b0;
      byte_b       = req_in_byte;
      push_data    = '0;
      unique case (req_type)
         REQ_BYTE: begin
            if (mode_ff == MODE_OCTAL && req_in_byte[7:3] == OCT_DIGIT_HIGH) begin
               if (digits_ff == OCT_LAST_DIGIT) begin
                  has_b     = 1'b1;
                  byte_b    = oct_next;
                  mode_in   = MODE_NORMAL;
                  digits_in = 2'd0;
                  accum_in  = 8'd0;
               end else begin
                  digits_in = digits_ff + 2'd1;
                  accum_in  = oct_next;
               end
            end else begin
               has_a     = (mode_ff == MODE_OCTAL);
               mode_in   = MODE_NORMAL;
               digits_in = 2'd0;
               accum_in  = 8'd0;
               if (mode_ff == MODE_ESCAPE) begin
                  has_b = 1'b1;
                  case (req_in_byte)
                     CH_LOWER_B: byte_b = CH_BS;
                     CH_LOWER_F: byte_b = CH_FF;
                     CH_LOWER_N: byte_b = CH_NEWLINE;
                     CH_LOWER_R: byte_b = CH_CR;
                     CH_LOWER_T: byte_b = CH_TAB;
                     CH_LOWER_V: byte_b = CH_VT;
                     CH_LOWER_C: begin
                        has_b        = 1'b0;
                        cancelled_in = 1'b1;
                     end
                     CH_ZERO: begin
                        has_b   = 1'b0;
                        mode_in = MODE_OCTAL;
                     end
                     default: byte_b = req_in_byte;
                  endcase
               end else if (req_in_byte == CH_BACKSLASH) begin
                  mode_in = MODE_ESCAPE;
               end else begin
                  has_b = 1'b1;
               end
            end
         end
         REQ_BOUNDARY: begin
            has_a     = (mode_ff == MODE_OCTAL);
            has_b     = 1'b1;
            byte_b    = CH_SPACE;
            mode_in   = MODE_NORMAL;
            digits_in = 2'd0;
            accum_in  = 8'd0;
         end
         REQ_END: begin
            has_a              = (mode_ff == MODE_OCTAL);
            has_b              = !no_newline_ff && !cancelled_ff;
            byte_b             = CH_NEWLINE;
            mode_in            = MODE_NORMAL;
            digits_in          = 2'd0;
            accum_in           = 8'd0;
            cancelled_in       = 1'b0;
            push_data.list_end = 1'b1;
         end
         default: begin
         end
      endcase
      push_data.two = has_a && has_b;
      if (has_a) begin
         push_data.byte0 = accum_ff;
         push_data.byte1 = byte_b;
      end else begin
         push_data.byte0 = byte_b;
         push_data.byte1 = byte_b;
      end
   end

   assign push = accept && (has_a || has_b);

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff       <= MODE_NORMAL;
         digits_ff     <= 2'd0;
         accum_ff      <= 8'd0;
         cancelled_ff  <= 1'b0;
         no_newline_ff <= 1'b0;
      end else begin
         if (csr_wr_en) begin
            no_newline_ff <= csr_wr_data;
         end
         if (accept) begin
            mode_ff      <= mode_in;
            digits_ff    <= digits_in;
            accum_ff     <= accum_in;
            cancelled_ff <= cancelled_in;
         end
      end
   end

endmodule

@@ rtl/esd_queue.sv @@
// Short entry queue between the decoder front end and the output back end.
`timescale 1ns / 1ps
module esd_queue import esd_pkg::*; (
   input  logic      clock,
   input  logic      reset,
   input  logic      push,
   input  entry_type push_data,
   output logic      full,
   input  logic      pop,
   output logic      not_empty,
   output entry_type pop_data
);

   entry_type           entries_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0]   head_ff, head_in;
   logic [QPTR_W-1:0]   tail_ff, tail_in;
   logic [QPTR_W:0]     count_ff, count_in;

   assign full      = (count_ff == (QPTR_W+1)'(QUEUE_DEPTH));
   assign not_empty = (count_ff != '0);
   assign pop_data  = entries_ff[head_ff];

   always_comb begin
      head_in  = pop  ? head_ff + QPTR_W'(1) : head_ff;
      tail_in  = push ? tail_ff + QPTR_W'(1) : tail_ff;
      count_in = count_ff + (QPTR_W+1)'(push) - (QPTR_W+1)'(pop);
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entries_ff[tail_ff] <= push_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff  <= '0;
         tail_ff  <= '0;
         count_ff <= '0;
      end else begin
         head_ff  <= head_in;
         tail_ff  <= tail_in;
         count_ff <= count_in;
      end
   end

endmodule

@@ rtl/esd_back.sv @@
// Back end: splits queue entries into result transactions and holds the output register.
`timescale 1ns / 1ps
module esd_back import esd_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  logic       entry_valid,
   input  entry_type  entry,
   output logic       pop,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   output logic [7:0] rsp_out_byte,
   output logic       rsp_run_last,
   output logic       rsp_stream_end
);

   logic       sel_ff, sel_in;
   logic       valid_ff, valid_in;
   logic [7:0] byte_ff;
   logic       run_last_ff, stream_end_ff;
   logic       load, last;

   assign load = entry_valid && (!valid_ff || rsp_ready);
   assign last = !entry.two || sel_ff;
   assign pop  = load && last;

   always_comb begin
      sel_in   = sel_ff;
      valid_in = valid_ff;
      if (load) begin
         sel_in   = !last;
         valid_in = 1'b1;
      end else if (rsp_ready) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sel_ff   <= 1'b0;
         valid_ff <= 1'b0;
      end else begin
         sel_ff   <= sel_in;
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         byte_ff       <= sel_ff ? entry.byte1 : entry.byte0;
         run_last_ff   <= last;
         stream_end_ff <= last && entry.list_end;
      end
   end

   assign rsp_valid      = valid_ff;
   assign rsp_out_byte   = byte_ff;
   assign rsp_run_last   = run_last_ff;
   assign rsp_stream_end = stream_end_ff;

endmodule

@@ rtl/escape_sequence_decoder_core.sv @@
// Top level of the backslash escape decoder for echo argument lists.
// One request transaction is accepted per cycle while the 4-entry queue between the decoder
// front end and the output back end has room. Each request yields zero, one or two result
// transactions; the back end sends one result per cycle unless stalled by rsp_ready, so a
// request that yields two results (a flushed octal value followed by a byte, space or newline)
// sends them in turn, and a request that yields none takes no output cycle. Each result is
// queued and then loaded into the output register that drives rsp_valid. csr_wr_data sets
// the no-newline bit, which the user must write only while the block is idle; it is not enforced.
`timescale 1ns / 1ps
module escape_sequence_decoder_core import esd_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  logic       csr_wr_en,
   input  logic       csr_wr_data,
   input  logic       req_valid,
   output logic       req_ready,
   input  logic [1:0] req_type,
   input  logic [7:0] req_in_byte,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   output logic [7:0] rsp_out_byte,
   output logic       rsp_run_last,
   output logic       rsp_stream_end
);

   logic      push, pop, full, not_empty;
   entry_type push_data, pop_data;

   esd_front u_front (
      .clock       (clock),
      .reset       (reset),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_type    (req_type),
      .req_in_byte (req_in_byte),
      .queue_full  (full),
      .push        (push),
      .push_data   (push_data)
   );

   esd_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_data (push_data),
      .full      (full),
      .pop       (pop),
      .not_empty (not_empty),
      .pop_data  (pop_data)
   );

   esd_back u_back (
      .clock          (clock),
      .reset          (reset),
      .entry_valid    (not_empty),
      .entry          (pop_data),
      .pop            (pop),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_out_byte   (rsp_out_byte),
      .rsp_run_last   (rsp_run_last),
      .rsp_stream_end (rsp_stream_end)
   );

endmodule

@@ rtl/esd_checker.sv @@
// Port-level checker for the escape sequence decoder, bound to the top level.
`timescale 1ns / 1ps
module esd_checker (
   input logic       clock,
   input logic       reset,
   input logic       csr_wr_en,
   input logic       csr_wr_data,
   input logic       req_valid,
   input logic       req_ready,
   input logic [1:0] req_type,
   input logic [7:0] req_in_byte,
   input logic       rsp_valid,
   input logic       rsp_ready,
   input logic [7:0] rsp_out_byte,
   input logic       rsp_run_last,
   input logic       rsp_stream_end
);

   a_reset_clears_rsp: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result valid right after reset");

   a_end_is_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stream_end |-> rsp_run_last)
      else $error("stream end without run last");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_out_byte)
         && $stable(rsp_run_last) && $stable(rsp_stream_end))
      else $error("stalled result transaction changed");

endmodule

bind escape_sequence_decoder_core esd_checker u_esd_checker (.*);
